@@ hw/rtl/tlc_pkg.sv @@
// Package for the two-way traffic light controller.
// Holds phase and command codes, register indexes, beat layout and display helpers.
// No dependencies.
`default_nettype none

package tlc_pkg;

	// North-south / east-west phase codes
	typedef enum logic [2:0] {
		PH_GREEN       = 3'd0,
		PH_GREEN_BLINK = 3'd1,
		PH_YELLOW      = 3'd2,
		PH_RED         = 3'd3,
		PH_RED_BLINK   = 3'd4
	} phase_t;

	// Command carried in tuser of the input beat
	typedef enum logic [1:0] {
		CMD_SECOND = 2'd0,
		CMD_BLINK  = 2'd1,
		CMD_MAINT  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_GREEN     = 2'd0,
		REG_YELLOW    = 2'd1,
		REG_RED       = 2'd2,
		REG_RESET_MNT = 2'd3
	} cfg_reg_t;

	localparam int unsigned CountW   = 7;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 7;
	localparam int unsigned InDataW  = 8;
	localparam int unsigned OutDataW = 48;

	// Output beat layout (lowest bit first)
	localparam int unsigned OutLampLo   = 0;
	localparam int unsigned OutNsTensLo = 6;
	localparam int unsigned OutNsOnesLo = 14;
	localparam int unsigned OutEwTensLo = 22;
	localparam int unsigned OutEwOnesLo = 30;
	localparam int unsigned OutNsPhLo   = 38;
	localparam int unsigned OutEwPhLo   = 41;

	localparam logic [CountW-1:0] GreenReset  = 7'd30;
	localparam logic [CountW-1:0] YellowReset = 7'd3;
	localparam logic [CountW-1:0] RedReset    = 7'd33;
	localparam logic [CountW-1:0] EwOffset    = 7'd3;
	localparam logic [CountW-1:0] BlinkLimit  = 7'd10;
	localparam logic [CountW-1:0] EwRedLimit  = 7'd7;
	localparam logic [CountW-1:0] EwGrnLimit  = 7'd13;
	localparam logic [7:0]        DispMax     = 8'd99;

	// Seven-segment code, bit 0 is segment a
	function automatic logic [7:0] seg_f(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// East-west phase derived from north-south phase and count
	function automatic phase_t ew_phase_f(input phase_t ph, input logic [CountW-1:0] cd);
		phase_t r;
		case (ph)
			PH_GREEN, PH_GREEN_BLINK: r = (cd >= EwRedLimit) ? PH_RED : PH_RED_BLINK;
			PH_YELLOW:                r = PH_RED_BLINK;
			default: begin
				if (cd <= EwOffset)
					r = PH_YELLOW;
				else
					r = (cd >= EwGrnLimit) ? PH_GREEN : PH_GREEN_BLINK;
			end
		endcase
		return r;
	endfunction

	// East-west count derived from north-south phase and count
	function automatic logic [7:0] ew_count_f(input phase_t ph, input logic [CountW-1:0] cd);
		logic [7:0] r;
		if (ph == PH_GREEN || ph == PH_GREEN_BLINK)
			r = {1'b0, cd} + {1'b0, EwOffset};
		else if (cd <= EwOffset)
			r = {1'b0, cd};
		else
			r = {1'b0, cd - EwOffset};
		return r;
	endfunction

	// Active-low lamp group {r, y, g} for one blink tick
	function automatic logic [2:0] lamp_f(input phase_t ph, input logic [2:0] l);
		logic [2:0] r;
		case (ph)
			PH_GREEN:       r = 3'b110;
			PH_GREEN_BLINK: r = {2'b11, ~l[0]};
			PH_YELLOW:      r = {1'b1, ~l[1], 1'b1};
			PH_RED:         r = 3'b011;
			default:        r = {~l[2], 2'b11};
		endcase
		return r;
	endfunction

	// Two-digit display, clamped at 99, tens blank when zero
	function automatic logic [15:0] show_f(input logic [7:0] v);
		logic [6:0]  c;
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [3:0]  ones;
		logic [7:0]  t_seg;
		c     = (v > DispMax) ? 7'(DispMax) : v[6:0];
		// tens = c / 10 by reciprocal, exact for c below 100
		prod  = 14'(c) * 14'd103;
		tens  = prod[13:10];
		ones  = 4'(c - 7'(tens) * 7'd10);
		t_seg = (tens == 4'd0) ? 8'h00 : seg_f(tens);
		return {seg_f(ones), t_seg};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/traffic_light_countdown_controller.sv @@
// Two-way traffic light controller: timer, phase walk, lamp drive and digit decode.
// Depends on tlc_pkg.
//
// Takes one command beat per clock and returns exactly one result beat for each, in the
// cycle after acceptance. The state update and the display decode sit between the
// input handshake and a single output register; the only limit on rate is that output
// register, so a beat is taken whenever the register is empty or being drained in the
// same cycle. Configuration writes take effect at the next clock edge and must only
// be issued while no result is pending.
`default_nettype none

module traffic_light_countdown_controller
	import tlc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// command input stream
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [InDataW-1:0]  s_axis_tdata,   // [0] maint_request, [7:1] zero
	input  wire logic [1:0]          s_axis_tuser,   // [1:0] command
	// result output stream
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [0] ns_green_n, [1] ns_yellow_n, [2] ns_red_n, [3] ew_green_n, [4] ew_yellow_n,
	// [5] ew_red_n, [13:6] ns_tens_segments, [21:14] ns_ones_segments,
	// [29:22] ew_tens_segments, [37:30] ew_ones_segments, [40:38] ns_phase,
	// [43:41] ew_phase, [47:44] zero
	output logic [OutDataW-1:0]      m_axis_tdata,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	logic              s_fire;
	cmd_t              cmd;
	logic              req;

	logic [CountW-1:0] green_q, yellow_q, red_q;
	logic              rst_mnt_q;

	phase_t            phase_q, phase_nx;
	logic [CountW-1:0] cd_q, cd_nx, cd_dec;
	logic              maint_q, maint_nx;
	logic [5:0]        lamp_q, lamp_nx;

	phase_t            ew_ph_nx;
	logic [15:0]       ns_disp, ew_disp;
	logic [OutDataW-1:0] res;

	logic              out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	assign cmd    = cmd_t'(s_axis_tuser);
	assign req    = s_axis_tdata[0];
	assign s_fire = s_axis_tvalid && s_axis_tready;

	// Output register frees up when empty or drained this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_q   <= GreenReset;
			yellow_q  <= YellowReset;
			red_q     <= RedReset;
			rst_mnt_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GREEN:     green_q   <= cfg_data;
				REG_YELLOW:    yellow_q  <= cfg_data;
				REG_RED:       red_q     <= cfg_data;
				REG_RESET_MNT: rst_mnt_q <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Next state for one command
	always_comb begin
		phase_nx = phase_q;
		cd_nx    = cd_q;
		maint_nx = maint_q;
		lamp_nx  = lamp_q;
		cd_dec   = (cd_q != '0) ? cd_q - 7'd1 : '0;
		unique case (cmd)
			CMD_SECOND: begin
				if (!maint_q) begin
					cd_nx = cd_dec;
					case (phase_q)
						PH_GREEN: begin
							if (cd_dec <= BlinkLimit)
								phase_nx = PH_GREEN_BLINK;
						end
						PH_GREEN_BLINK: begin
							if (cd_dec == '0) begin
								phase_nx = PH_YELLOW;
								cd_nx    = yellow_q;
							end
						end
						PH_YELLOW: begin
							if (cd_dec == '0) begin
								phase_nx = PH_RED;
								cd_nx    = red_q;
							end
						end
						PH_RED: begin
							if (cd_dec <= BlinkLimit)
								phase_nx = PH_RED_BLINK;
						end
						default: begin
							if (cd_dec == '0) begin
								phase_nx = PH_GREEN;
								cd_nx    = green_q;
							end
						end
					endcase
				end
			end
			CMD_BLINK: begin
				if (maint_q)
					lamp_nx = {1'b1, ~lamp_q[4], 2'b11, ~lamp_q[1], 1'b1};
				else
					lamp_nx = {lamp_f(ew_phase_f(phase_q, cd_q), lamp_q[5:3]),
						lamp_f(phase_q, lamp_q[2:0])};
			end
			CMD_MAINT: begin
				maint_nx = req;
				if (req && rst_mnt_q) begin
					phase_nx = PH_GREEN;
					cd_nx    = green_q;
				end
			end
			default: ;
		endcase
	end

	// Result from the updated state
	always_comb begin
		ew_ph_nx = ew_phase_f(phase_nx, cd_nx);
		ns_disp  = maint_nx ? 16'h0000 : show_f({1'b0, cd_nx});
		ew_disp  = maint_nx ? 16'h0000 : show_f(ew_count_f(phase_nx, cd_nx));
		res      = '0;
		res[OutLampLo +: 6]   = lamp_nx;
		res[OutNsTensLo +: 8] = ns_disp[7:0];
		res[OutNsOnesLo +: 8] = ns_disp[15:8];
		res[OutEwTensLo +: 8] = ew_disp[7:0];
		res[OutEwOnesLo +: 8] = ew_disp[15:8];
		res[OutNsPhLo +: 3]   = phase_nx;
		res[OutEwPhLo +: 3]   = ew_ph_nx;
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GREEN;
			cd_q    <= GreenReset;
			maint_q <= 1'b0;
			lamp_q  <= 6'h3F;
		end else if (s_fire) begin
			phase_q <= phase_nx;
			cd_q    <= cd_nx;
			maint_q <= maint_nx;
			lamp_q  <= lamp_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_fire)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_fire)
			out_data_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Timer is frozen in maintenance
	a_maint_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_SECOND && maint_q |=> $stable(cd_q) && $stable(phase_q))
		else $error("countdown moved during maintenance");

	// Pending result in maintenance shows blank digits
	a_maint_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && maint_q |-> m_axis_tdata[OutEwOnesLo+7:OutNsTensLo] == '0)
		else $error("digits not blank in maintenance");

	// Entering maintenance with restart enabled returns to green
	a_maint_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_MAINT && req && rst_mnt_q && !cfg_we
		|=> phase_q == PH_GREEN && cd_q == green_q)
		else $error("maintenance did not restart the cycle");

	// A blink tick never lights more than one lamp per direction
	a_one_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_BLINK
		|=> $countones(lamp_q[2:0]) >= 2 && $countones(lamp_q[5:3]) >= 2)
		else $error("more than one lamp lit in a direction");

endmodule

`default_nettype wire

@@ dv/traffic_light_countdown_controller_tb.sv @@
`timescale 1ns / 1ps
// Testbench for traffic_light_countdown_controller: directed and random command beats
// with random stalls on both streams, an in-bench predictor of lamps, digits and phases.
// Depends on tlc_pkg and the controller RTL.

module traffic_light_countdown_controller_tb
	import tlc_pkg::*;
();

	localparam int unsigned IdleLimit  = 2000;
	localparam int unsigned PhaseBeats = 150;
	localparam int unsigned NumFields  = 13;

	typedef struct packed {
		cmd_t cmd;
		logic req;
	} cmd_beat_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// DUT ports
	logic                s_axis_tvalid = 1'b0;
	wire                 s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata  = '0;  // [0] maint_request, [7:1] zero
	logic [1:0]          s_axis_tuser  = '0;  // [1:0] command
	wire                 m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	wire [OutDataW-1:0]  m_axis_tdata;        // lamps, four digit codes, ns/ew phase
	logic                cfg_we        = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index     = '0;
	logic [CfgDataW-1:0] cfg_data      = '0;

	traffic_light_countdown_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// result beat fields, lowest bit first
	int unsigned field_w [NumFields] = '{1, 1, 1, 1, 1, 1, 8, 8, 8, 8, 3, 3, 4};
	string field_name [NumFields] = '{"ns_green_n", "ns_yellow_n", "ns_red_n",
		"ew_green_n", "ew_yellow_n", "ew_red_n", "ns_tens_segments",
		"ns_ones_segments", "ew_tens_segments", "ew_ones_segments",
		"ns_phase", "ew_phase", "padding"};

	// predictor copy of registers and state
	logic [CountW-1:0] green_len        = GreenReset;
	logic [CountW-1:0] amber_len        = YellowReset;
	logic [CountW-1:0] red_len          = RedReset;
	logic              restart_on_maint = 1'b1;
	phase_t            ns_phase_m       = PH_GREEN;
	logic [CountW-1:0] ns_left          = GreenReset;
	logic              in_maint         = 1'b0;
	logic [5:0]        lamps_n          = 6'h3F;

	// bench bookkeeping
	cmd_beat_t          cmd_backlog[$];
	logic [OutDataW-1:0] due_results[$];
	int unsigned errors     = 0;
	int unsigned beats_out  = 0;
	int unsigned idle_count = 0;
	int unsigned tx_wait    = 0;
	int unsigned tx_burst   = 0;
	int unsigned rx_wait    = 0;
	int unsigned rx_burst   = 0;

	function automatic logic [7:0] digit_seg(input int unsigned d);
		case (d)
			0: return 8'h3F;
			1: return 8'h06;
			2: return 8'h5B;
			3: return 8'h4F;
			4: return 8'h66;
			5: return 8'h6D;
			6: return 8'h7D;
			7: return 8'h07;
			8: return 8'h7F;
			default: return 8'h6F;
		endcase
	endfunction

	// east-west phase follows the north-south phase and remaining seconds
	function automatic phase_t cross_phase(input phase_t p, input logic [CountW-1:0] c);
		if (p == PH_GREEN || p == PH_GREEN_BLINK)
			return (c >= EwRedLimit) ? PH_RED : PH_RED_BLINK;
		if (p == PH_YELLOW)
			return PH_RED_BLINK;
		if (c <= EwOffset)
			return PH_YELLOW;
		return (c >= EwGrnLimit) ? PH_GREEN : PH_GREEN_BLINK;
	endfunction

	function automatic logic [7:0] cross_count(input phase_t p, input logic [CountW-1:0] c);
		if (p == PH_GREEN || p == PH_GREEN_BLINK)
			return {1'b0, c} + 8'd3;
		if (c <= EwOffset)
			return {1'b0, c};
		return {1'b0, c} - 8'd3;
	endfunction

	// one lamp group {r, y, g}, active low; blinking lamps flip their lit state
	function automatic logic [2:0] next_group(input phase_t p, input logic [2:0] cur);
		logic [2:0] lit;
		case (p)
			PH_GREEN:       lit = 3'b001;
			PH_GREEN_BLINK: lit = {2'b00, cur[0]};
			PH_YELLOW:      lit = {1'b0, cur[1], 1'b0};
			PH_RED:         lit = 3'b100;
			default:        lit = {cur[2], 2'b00};
		endcase
		return ~lit;
	endfunction

	// {ones, tens} segment codes; clamp at 99, blank tens, all dark in maintenance
	function automatic logic [15:0] count_digits(input logic [7:0] v, input logic dark);
		int unsigned n;
		if (dark)
			return 16'h0000;
		n = (v > 8'd99) ? 99 : int'(v);
		return {digit_seg(n % 10), (n >= 10) ? digit_seg(n / 10) : 8'h00};
	endfunction

	// advance the light state by one command and build the expected result beat
	function automatic logic [OutDataW-1:0] light_step(input cmd_t c, input logic req);
		logic [OutDataW-1:0] r;
		logic [15:0]         nsd;
		logic [15:0]         ewd;
		phase_t              ew;
		case (c)
			CMD_SECOND: begin
				if (!in_maint) begin
					if (ns_left != 0)
						ns_left = ns_left - 1'b1;
					case (ns_phase_m)
						PH_GREEN: begin
							if (ns_left <= BlinkLimit)
								ns_phase_m = PH_GREEN_BLINK;
						end
						PH_GREEN_BLINK: begin
							if (ns_left == 0) begin
								ns_phase_m = PH_YELLOW;
								ns_left    = amber_len;
							end
						end
						PH_YELLOW: begin
							if (ns_left == 0) begin
								ns_phase_m = PH_RED;
								ns_left    = red_len;
							end
						end
						PH_RED: begin
							if (ns_left <= BlinkLimit)
								ns_phase_m = PH_RED_BLINK;
						end
						default: begin
							if (ns_left == 0) begin
								ns_phase_m = PH_GREEN;
								ns_left    = green_len;
							end
						end
					endcase
				end
			end
			CMD_BLINK: begin
				if (in_maint) begin
					// both yellows flash, everything else dark
					lamps_n = {1'b1, ~lamps_n[4], 2'b11, ~lamps_n[1], 1'b1};
				end else begin
					ew = cross_phase(ns_phase_m, ns_left);
					lamps_n[2:0] = next_group(ns_phase_m, lamps_n[2:0]);
					lamps_n[5:3] = next_group(ew, lamps_n[5:3]);
				end
			end
			CMD_MAINT: begin
				in_maint = req;
				if (req && restart_on_maint) begin
					ns_phase_m = PH_GREEN;
					ns_left    = green_len;
				end
			end
			default: ;
		endcase
		ew  = cross_phase(ns_phase_m, ns_left);
		nsd = count_digits({1'b0, ns_left}, in_maint);
		ewd = count_digits(cross_count(ns_phase_m, ns_left), in_maint);
		r = '0;
		r[OutLampLo +: 6]   = lamps_n;
		r[OutNsTensLo +: 8] = nsd[7:0];
		r[OutNsOnesLo +: 8] = nsd[15:8];
		r[OutEwTensLo +: 8] = ewd[7:0];
		r[OutEwOnesLo +: 8] = ewd[15:8];
		r[OutNsPhLo +: 3]   = ns_phase_m;
		r[OutEwPhLo +: 3]   = ew;
		return r;
	endfunction

	// stall length: mostly none or short, a few long, now and then a burst without stalls
	function automatic int unsigned pick_pause(inout int unsigned burst);
		int unsigned r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("beat %0d %s: got 0x%0h, want 0x%0h", beats_out, what, got, want);
		errors++;
	endtask

	task automatic queue_cmd(input cmd_t c, input logic req);
		cmd_backlog.push_back('{cmd: c, req: req});
	endtask

	// mostly second ticks and blinks; maintenance now and then; a few unused codes
	task automatic queue_random();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			queue_cmd(CMD_SECOND, 1'($urandom_range(0, 1)));
		else if (r < 85)
			queue_cmd(CMD_BLINK, 1'($urandom_range(0, 1)));
		else if (r < 95)
			queue_cmd(CMD_MAINT, ($urandom_range(0, 9) < 4));
		else
			queue_cmd(CMD_NONE, 1'($urandom_range(0, 1)));
	endtask

	// waits until every queued command is sent and every expected beat is back
	task automatic settle();
		while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GREEN:  green_len = v;
			REG_YELLOW: amber_len = v;
			REG_RED:    red_len   = v;
			default:    restart_on_maint = v[0];
		endcase
	endtask

	task automatic run_setting(input logic [CountW-1:0] g, input logic [CountW-1:0] y,
			input logic [CountW-1:0] rd, input logic restart, input int unsigned n);
		settle();
		write_reg(REG_GREEN, g);
		write_reg(REG_YELLOW, y);
		write_reg(REG_RED, rd);
		write_reg(REG_RESET_MNT, CfgDataW'(restart));
		repeat (n) queue_random();
	endtask

	// command beat driver
	always @(posedge clk) begin : cmd_driver
		logic      fire;
		cmd_beat_t b;
		if (arst_n) begin
			fire = s_axis_tvalid && s_axis_tready;
			if (fire)
				due_results.push_back(light_step(cmd_t'(s_axis_tuser), s_axis_tdata[0]));
			if (!s_axis_tvalid || fire) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					b = cmd_backlog.pop_front();
					s_axis_tuser  <= b.cmd;
					s_axis_tdata  <= InDataW'(b.req);
					s_axis_tvalid <= 1'b1;
					tx_wait = pick_pause(tx_burst);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result beat monitor and receiver stalls
	always @(posedge clk) begin : result_monitor
		logic [OutDataW-1:0] want;
		int unsigned         lo;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					want = due_results.pop_front();
					lo   = 0;
					for (int i = 0; i < NumFields; i++) begin
						if (((m_axis_tdata ^ want) >> lo) & ((48'd1 << field_w[i]) - 1))
							report_mismatch(field_name[i],
								int'((m_axis_tdata >> lo) & ((48'd1 << field_w[i]) - 1)),
								int'((want >> lo) & ((48'd1 << field_w[i]) - 1)));
						lo += field_w[i];
					end
				end
				beats_out++;
			end
			if (rx_wait == 0) begin
				m_axis_tready <= 1'b1;
				rx_wait = pick_pause(rx_burst);
			end else begin
				m_axis_tready <= 1'b0;
				rx_wait--;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= IdleLimit) begin
				$display("[traffic_light_countdown_controller] ERROR");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: unused code, lamps from dark, maintenance flash and freeze
		queue_cmd(CMD_NONE, 1'b0);
		queue_cmd(CMD_BLINK, 1'b0);
		queue_cmd(CMD_SECOND, 1'b1);
		queue_cmd(CMD_SECOND, 1'b0);
		queue_cmd(CMD_BLINK, 1'b1);
		queue_cmd(CMD_MAINT, 1'b1);
		queue_cmd(CMD_BLINK, 1'b0);
		queue_cmd(CMD_BLINK, 1'b0);
		queue_cmd(CMD_SECOND, 1'b0);
		queue_cmd(CMD_NONE, 1'b1);
		queue_cmd(CMD_MAINT, 1'b0);
		queue_cmd(CMD_SECOND, 1'b0);
		queue_cmd(CMD_BLINK, 1'b0);
		settle();

		// zero durations: the count sits at zero and every phase ends on the next tick
		write_reg(REG_GREEN, 7'd0);
		write_reg(REG_YELLOW, 7'd0);
		write_reg(REG_RED, 7'd0);
		queue_cmd(CMD_MAINT, 1'b1);
		queue_cmd(CMD_MAINT, 1'b0);
		repeat (5) begin
			queue_cmd(CMD_SECOND, 1'b0);
			queue_cmd(CMD_BLINK, 1'b0);
		end

		// random phases over several register settings, extremes first
		run_setting(7'd1, 7'd1, 7'd1, 1'b0, PhaseBeats);
		run_setting(7'd127, 7'd99, 7'd99, 1'b1, PhaseBeats);
		run_setting(7'd96, 7'd1, 7'd99, 1'b0, PhaseBeats);
		run_setting(7'd11, 7'd2, 7'd12, 1'b1, PhaseBeats);
		repeat (4)
			run_setting(7'($urandom_range(1, 40)), 7'($urandom_range(1, 9)),
				7'($urandom_range(1, 40)), 1'($urandom_range(0, 1)), PhaseBeats);
		settle();
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("[traffic_light_countdown_controller] OK");
		else
			$display("[traffic_light_countdown_controller] ERROR");
		$finish;
	end

endmodule
